FILE: rtl/ssnf_pkg.sv
// Shared types, constants and the digit segment table for the seven-segment
// number formatter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssnf_pkg;

  localparam int unsigned MantW     = 16;
  localparam int unsigned PrecW     = 3;
  localparam int unsigned MagW      = 14;   // holds up to 9999
  localparam int unsigned ProdW     = 28;

  localparam logic [PrecW-1:0] MAX_PRECISION = 3'd3;

  localparam logic [MantW-1:0] NEG_LIMIT = 16'd999;
  localparam logic [MantW-1:0] POS_LIMIT = 16'd9999;
  localparam logic [7:0]       TIME_LIMIT = 8'd99;

  // Reciprocal constants: exact quotients for the value ranges used here
  localparam logic [ProdW-1:0] RECIP_10   = 28'd6554;   // >> 16
  localparam logic [ProdW-1:0] RECIP_100  = 28'd5243;   // >> 19
  localparam logic [ProdW-1:0] RECIP_1000 = 28'd8389;   // >> 23
  localparam logic [15:0]      RECIP_TIME = 16'd205;    // >> 11

  localparam logic [7:0] SEG_NONE  = 8'h00;
  localparam logic [7:0] SEG_A     = 8'h01;
  localparam logic [7:0] SEG_B     = 8'h02;
  localparam logic [7:0] SEG_D     = 8'h08;
  localparam logic [7:0] SEG_G     = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;

  typedef enum logic [1:0] {
    OP_NUMBER = 2'd0,
    OP_TIME   = 2'd1,
    OP_BLANK  = 2'd2,
    OP_ERROR  = 2'd3
  } ssnf_op_e;

  typedef struct packed {
    ssnf_op_e          op;
    logic signed [15:0] mantissa;
    logic [2:0]        precision;
    logic [7:0]        hour;
    logic [7:0]        minute;
  } ssnf_in_t;

  typedef struct packed {
    logic [7:0] slot_zero;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
  } ssnf_out_t;

  // Between the split and render stages
  typedef struct packed {
    logic             valid;
    ssnf_op_e         op;
    logic             err;
    logic             neg;
    logic [PrecW-1:0] prec;
    logic [MagW-1:0]  mag;
    logic [9:0]       q10;
    logic [6:0]       q100;
    logic [3:0]       q1000;
    logic [6:0]       hour;
    logic [3:0]       hour_tens;
    logic [6:0]       minute;
    logic [3:0]       minute_tens;
  } ssnf_mid_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = SEG_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssnf_split.sv
// First stage: magnitude, range checks and decimal quotients by reciprocal.
// Depends on ssnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssnf_split (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire ssnf_pkg::ssnf_in_t item_i,
  output ssnf_pkg::ssnf_mid_t    mid_o
);

  logic                          neg;
  logic [ssnf_pkg::MantW-1:0]    mag_full;
  logic                          num_err;
  logic                          time_err;
  logic [ssnf_pkg::MagW-1:0]     mag;
  logic [ssnf_pkg::ProdW-1:0]    p10, p100, p1000;
  logic [15:0]                   ph, pm;
  ssnf_pkg::ssnf_mid_t           mid_d, mid_q;
  logic                          mid_valid_q;

  always_comb begin
    neg      = item_i.mantissa[15];
    mag_full = neg ? (~item_i.mantissa + 16'd1) : item_i.mantissa;
    num_err  = (item_i.precision > ssnf_pkg::MAX_PRECISION) ||
               (neg ? (mag_full > ssnf_pkg::NEG_LIMIT) : (mag_full > ssnf_pkg::POS_LIMIT));
    time_err = (item_i.hour > ssnf_pkg::TIME_LIMIT) || (item_i.minute > ssnf_pkg::TIME_LIMIT);
    mag      = mag_full[ssnf_pkg::MagW-1:0];

    p10   = ssnf_pkg::ProdW'(mag) * ssnf_pkg::RECIP_10;
    p100  = ssnf_pkg::ProdW'(mag) * ssnf_pkg::RECIP_100;
    p1000 = ssnf_pkg::ProdW'(mag) * ssnf_pkg::RECIP_1000;
    ph    = 16'(item_i.hour) * ssnf_pkg::RECIP_TIME;
    pm    = 16'(item_i.minute) * ssnf_pkg::RECIP_TIME;

    mid_d.valid       = valid_i;
    mid_d.op          = item_i.op;
    unique case (item_i.op)
      ssnf_pkg::OP_NUMBER: mid_d.err = num_err;
      ssnf_pkg::OP_TIME:   mid_d.err = time_err;
      ssnf_pkg::OP_BLANK:  mid_d.err = 1'b0;
      ssnf_pkg::OP_ERROR:  mid_d.err = 1'b1;
    endcase
    mid_d.neg         = neg;
    mid_d.prec        = item_i.precision;
    mid_d.mag         = mag;
    mid_d.q10         = p10[25:16];
    mid_d.q100        = p100[25:19];
    mid_d.q1000       = p1000[26:23];
    mid_d.hour        = item_i.hour[6:0];
    mid_d.hour_tens   = ph[14:11];
    mid_d.minute      = item_i.minute[6:0];
    mid_d.minute_tens = pm[14:11];
  end

  // valid resets, the rest is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  always_comb begin
    mid_o       = mid_q;
    mid_o.valid = mid_valid_q;
  end

endmodule

`default_nettype wire

FILE: rtl/ssnf_render.sv
// Second stage: digits, leading-zero blanking, point and mode select into
// the result register. Depends on ssnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssnf_render (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ssnf_pkg::ssnf_mid_t mid_i,
  output logic                     valid_o,
  output ssnf_pkg::ssnf_out_t      result_o
);

  logic [ssnf_pkg::MagW-1:0] rem0;
  logic [9:0]                rem1;
  logic [6:0]                rem2;
  logic [3:0]                dig [4];
  logic                      lz  [4];
  logic [7:0]                seg [4];
  logic [6:0]                h_ones, m_ones;
  ssnf_pkg::ssnf_out_t       res_d, res_q;
  logic                      valid_q;

  always_comb begin
    // remainder = x - 10*q, with 10*q as two shifts
    rem0   = mid_i.mag - (ssnf_pkg::MagW'(mid_i.q10) << 3) - (ssnf_pkg::MagW'(mid_i.q10) << 1);
    rem1   = mid_i.q10 - (10'(mid_i.q100) << 3) - (10'(mid_i.q100) << 1);
    rem2   = mid_i.q100 - (7'(mid_i.q1000) << 3) - (7'(mid_i.q1000) << 1);
    dig[0] = rem0[3:0];
    dig[1] = rem1[3:0];
    dig[2] = rem2[3:0];
    dig[3] = mid_i.q1000;

    // zero run from the top digit down
    lz[3] = (dig[3] == 4'd0);
    lz[2] = lz[3] && (dig[2] == 4'd0);
    lz[1] = lz[2] && (dig[1] == 4'd0);
    lz[0] = lz[1] && (dig[0] == 4'd0);

    for (int i = 0; i < 4; i++) begin
      seg[i] = (lz[i] && (3'(i) > mid_i.prec)) ? ssnf_pkg::SEG_NONE
                                                 : ssnf_pkg::digit_seg(dig[i]);
      if ((mid_i.prec != 3'd0) && (mid_i.prec == 3'(i))) begin
        seg[i] = seg[i] | ssnf_pkg::SEG_POINT;
      end
    end

    h_ones = mid_i.hour - (7'(mid_i.hour_tens) << 3) - (7'(mid_i.hour_tens) << 1);
    m_ones = mid_i.minute - (7'(mid_i.minute_tens) << 3) - (7'(mid_i.minute_tens) << 1);

    if (mid_i.err) begin
      res_d = '{default: ssnf_pkg::SEG_D};
    end else begin
      unique case (mid_i.op)
        ssnf_pkg::OP_NUMBER: begin
          // minus sign takes the leftmost slot, and any point meant for it
          res_d.slot_zero  = mid_i.neg ? ssnf_pkg::SEG_G : seg[3];
          res_d.slot_one   = seg[2];
          res_d.slot_two   = seg[1];
          res_d.slot_three = seg[0];
          res_d.slot_four  = ssnf_pkg::SEG_NONE;
        end
        ssnf_pkg::OP_TIME: begin
          res_d.slot_zero  = ssnf_pkg::digit_seg(mid_i.hour_tens);
          res_d.slot_one   = ssnf_pkg::digit_seg(h_ones[3:0]);
          res_d.slot_two   = ssnf_pkg::digit_seg(mid_i.minute_tens);
          res_d.slot_three = ssnf_pkg::digit_seg(m_ones[3:0]);
          res_d.slot_four  = ssnf_pkg::SEG_A | ssnf_pkg::SEG_B;
        end
        ssnf_pkg::OP_BLANK: begin
          res_d = '{default: ssnf_pkg::SEG_NONE};
        end
        ssnf_pkg::OP_ERROR: begin
          res_d = '{default: ssnf_pkg::SEG_D};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= mid_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/seven_segment_number_formatter.sv
// Top level of the seven-segment number formatter: input register, split
// and render stages. Depends on ssnf_pkg, ssnf_split and ssnf_render.
//
// Usage: drive a beat on in_i with start_i high; busy_o is never raised, so
// a beat is taken on every clock edge at which start_i is high. Each beat
// gives exactly one result on result_o, marked by result_valid_o for one
// cycle, once the beat has passed the input register, split register and
// result register. The receiver cannot stall: a result is only
// shown for that one cycle and must be captured then. Throughput is one
// beat per cycle; the rate is set by the three-register pipeline, whose
// longest path is the reciprocal multiply of the magnitude in the split
// stage. No state is kept between beats.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_number_formatter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire ssnf_pkg::ssnf_in_t in_i,
  output logic                    busy_o,
  output logic                    result_valid_o,
  output ssnf_pkg::ssnf_out_t     result_o
);

  logic                accept;
  logic                in_valid_q;
  ssnf_pkg::ssnf_in_t  in_q;
  ssnf_pkg::ssnf_mid_t mid;

  // pipeline never backs up, so the block is never busy
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  ssnf_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .item_i  (in_q),
    .mid_o   (mid)
  );

  ssnf_render u_render (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mid_i    (mid),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

FILE: rtl/ssnf_checker.sv
// Port-level checks for the seven-segment number formatter, bound to the
// top level. Depends on ssnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssnf_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                result_valid_o,
  input wire ssnf_pkg::ssnf_out_t result_o
);

  // every taken beat gives a result through the input, split and result registers
  a_beat_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##2 result_valid_o)
    else $error("beat taken without a result three cycles later");

  // no result without a taken beat that passed the input, split and result registers
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 3))
    else $error("result shown without a matching beat");

  // colon slot only ever carries blank, colon or error
  a_colon_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.slot_four == ssnf_pkg::SEG_NONE ||
                        result_o.slot_four == (ssnf_pkg::SEG_A | ssnf_pkg::SEG_B) ||
                        result_o.slot_four == ssnf_pkg::SEG_D))
    else $error("bad colon slot code");

  // error in the colon slot means the whole error pattern
  a_error_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.slot_four == ssnf_pkg::SEG_D) |->
      (result_o.slot_zero == ssnf_pkg::SEG_D && result_o.slot_one == ssnf_pkg::SEG_D &&
       result_o.slot_two == ssnf_pkg::SEG_D && result_o.slot_three == ssnf_pkg::SEG_D))
    else $error("partial error pattern");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire

FILE: tb/sv/seven_segment_number_formatter_test.sv
// Self-checking testbench for seven_segment_number_formatter: directed and
// random beats, a scoreboard that predicts the five segment slots of each beat.
// Depends on ssnf_pkg and the formatter RTL only.
`timescale 1ns / 1ps

module seven_segment_number_formatter_test;

  localparam int unsigned CYCLE_LIMIT = 400000;  // watchdog limit for a hung run
  localparam int unsigned RANDOM_BEATS = 1200;
  localparam int unsigned DRAIN_CYCLES = 8;      // three-register pipeline plus margin

  // Holds the segment slots expected for every beat taken and checks each
  // result against the oldest of them.
  class slot_scoreboard;
    ssnf_pkg::ssnf_out_t expected_slots[$];
    int failures = 0;

    function int pending();
      return expected_slots.size();
    endfunction

    task report_mismatch(string what);
      failures++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function logic [7:0] glyph(int unsigned d);
      case (d)
        0: return 8'h3F;
        1: return 8'h06;
        2: return 8'h5B;
        3: return 8'h4F;
        4: return 8'h66;
        5: return 8'h6D;
        6: return 8'h7D;
        7: return 8'h07;
        8: return 8'h7F;
        default: return 8'h6F;
      endcase
    endfunction

    // Segment pattern for one beat; slot 0 is the leftmost digit.
    function ssnf_pkg::ssnf_out_t format_beat(ssnf_pkg::ssnf_in_t b);
      int unsigned weight[4] = '{1, 10, 100, 1000};
      logic [7:0] slot[5];
      int value;
      int unsigned mag;
      int unsigned didx;
      int unsigned d;
      bit neg;
      bit err;
      foreach (slot[i]) slot[i] = ssnf_pkg::SEG_NONE;
      err = 1'b0;
      case (b.op)
        ssnf_pkg::OP_NUMBER: begin
          value = b.mantissa;
          neg = value < 0;
          mag = neg ? -value : value;
          err = (b.precision > ssnf_pkg::MAX_PRECISION) || (neg && mag > ssnf_pkg::NEG_LIMIT)
                || (!neg && mag > ssnf_pkg::POS_LIMIT);
          if (neg) slot[0] = ssnf_pkg::SEG_G;
          for (int unsigned pos = neg; pos < 4; pos++) begin
            didx = 3 - pos;
            d = (mag / weight[didx]) % 10;
            // blank a zero only when nothing above it is lit and it sits
            // left of the point
            if (!(d == 0 && mag < weight[didx] * 10 && didx > b.precision))
              slot[pos] = glyph(d);
            if (b.precision != 0 && didx == b.precision) slot[pos] |= ssnf_pkg::SEG_POINT;
          end
        end
        ssnf_pkg::OP_TIME: begin
          err = (b.hour > ssnf_pkg::TIME_LIMIT) || (b.minute > ssnf_pkg::TIME_LIMIT);
          slot[0] = glyph(b.hour / 10);
          slot[1] = glyph(b.hour % 10);
          slot[2] = glyph(b.minute / 10);
          slot[3] = glyph(b.minute % 10);
          slot[4] = ssnf_pkg::SEG_A | ssnf_pkg::SEG_B;
        end
        ssnf_pkg::OP_BLANK: ;
        default: err = 1'b1;
      endcase
      if (err) foreach (slot[i]) slot[i] = ssnf_pkg::SEG_D;
      return {slot[0], slot[1], slot[2], slot[3], slot[4]};
    endfunction

    function void note_beat(ssnf_pkg::ssnf_in_t b);
      expected_slots.push_back(format_beat(b));
    endfunction

    task check_result(ssnf_pkg::ssnf_out_t r);
      string slot_name[5] = '{"slot_zero", "slot_one", "slot_two", "slot_three",
                              "slot_four"};
      ssnf_pkg::ssnf_out_t want;
      logic [7:0] got_b;
      logic [7:0] want_b;
      if (expected_slots.size() == 0) begin
        report_mismatch($sformatf("result %010h with nothing outstanding", r));
        return;
      end
      want = expected_slots.pop_front();
      for (int i = 0; i < 5; i++) begin
        got_b = r[39 - 8 * i -: 8];
        want_b = want[39 - 8 * i -: 8];
        if (got_b !== want_b)
          report_mismatch($sformatf("%s got %02h want %02h", slot_name[i], got_b, want_b));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  ssnf_pkg::ssnf_in_t  in_i = '0;
  logic                busy_o;
  logic                result_valid_o;
  ssnf_pkg::ssnf_out_t result_o;

  slot_scoreboard sb = new();
  int unsigned cycle_count = 0;

  always #6 clk_i = ~clk_i;

  seven_segment_number_formatter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .in_i          (in_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Monitor: everything here is read in the active region at the edge, so it
  // sees the pre-edge values that the block itself samples.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) sb.note_beat(in_i);
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // Watchdog on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Random filler for the fields; a beat only overrides what it needs.
  function ssnf_pkg::ssnf_in_t junk_beat();
    logic [63:0] bits64;
    bits64 = {$urandom, $urandom};
    return bits64[$bits(ssnf_pkg::ssnf_in_t)-1:0];
  endfunction

  function ssnf_pkg::ssnf_in_t make_beat(ssnf_pkg::ssnf_op_e op, int mant, int unsigned prec,
                                         int unsigned hr, int unsigned mn);
    ssnf_pkg::ssnf_in_t b;
    b = junk_beat();
    b.op = op;
    b.mantissa = mant[15:0];
    b.precision = prec[2:0];
    b.hour = hr[7:0];
    b.minute = mn[7:0];
    return b;
  endfunction

  // Hold the beat on the inputs until an edge takes it.
  task drive_beat(ssnf_pkg::ssnf_in_t b);
    start_i <= 1'b1;
    in_i <= b;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start for the requested gap, with noise on the data lines.
  task idle_for(int unsigned n);
    if (n != 0) begin
      start_i <= 1'b0;
      in_i <= junk_beat();
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function ssnf_pkg::ssnf_in_t random_beat();
    ssnf_pkg::ssnf_in_t b;
    int value;
    int unsigned r;
    b = junk_beat();
    r = $urandom_range(0, 99);
    if (r < 55) b.op = ssnf_pkg::OP_NUMBER;
    else if (r < 80) b.op = ssnf_pkg::OP_TIME;
    else if (r < 90) b.op = ssnf_pkg::OP_BLANK;
    else b.op = ssnf_pkg::OP_ERROR;
    // Mostly displayable values, some near the limits, the rest anything.
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: value = int'($urandom_range(0, 10998)) - 999;
      5: value = int'($urandom_range(0, 200)) - 100;
      6: value = $urandom_range(0, 1) ? int'($urandom_range(9990, 10010))
                                      : int'($urandom_range(0, 20)) - 1010;
      default: value = $urandom;
    endcase
    b.mantissa = value[15:0];
    b.precision = 3'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 7));
    if ($urandom_range(0, 99) < 85) begin
      b.hour = 8'($urandom_range(0, 99));
      b.minute = 8'($urandom_range(0, 99));
    end
    return b;
  endfunction

  initial begin
    bit quiet;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: limits, leading zeros, point placement, every mode.
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 0, 0, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 9999, 0, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 10000, 0, 0, 0));      // too large
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, -999, 1, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, -1000, 0, 0, 0));      // too negative
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, -32768, 0, 255, 255));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 32767, 0, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 5, 3, 0, 0));          // 0.005
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, -5, 2, 0, 0));         // -0.05
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, -12, 3, 0, 0));        // point would sit on the minus
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 1234, 1, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 100, 2, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 7, 4, 0, 0));          // precision too large
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 0, 7, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_NUMBER, 0, 3, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_TIME, 0, 0, 0, 0));
    drive_beat(make_beat(ssnf_pkg::OP_TIME, 0, 0, 99, 99));
    drive_beat(make_beat(ssnf_pkg::OP_TIME, 0, 0, 23, 59));
    drive_beat(make_beat(ssnf_pkg::OP_TIME, 0, 0, 100, 5));          // hour out of range
    drive_beat(make_beat(ssnf_pkg::OP_TIME, 0, 0, 12, 255));         // minute out of range
    drive_beat(make_beat(ssnf_pkg::OP_BLANK, -1, 7, 255, 255));
    drive_beat(make_beat(ssnf_pkg::OP_ERROR, 0, 0, 0, 0));
    idle_for(5);

    // Random beats; roughly one stretch in four runs back to back.
    quiet = 1'b0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      drive_beat(random_beat());
      if (!quiet) idle_for(pick_gap());
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: seven_segment_number_formatter.f
rtl/ssnf_pkg.sv
rtl/ssnf_split.sv
rtl/ssnf_render.sv
rtl/seven_segment_number_formatter.sv
rtl/ssnf_checker.sv
tb/sv/seven_segment_number_formatter_test.sv
